// File: src/tpmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tabulated policy motor drive package
// Shared constants, register map codes, action codes and the table control
// struct used by the top level and the table store.
// ----------------------------------------------------------------------------
package tpmd_pkg;

  // Grid half spans in degrees with 8 fraction bits (grids run -H..+H).
  localparam int LARGE_PITCH_HALF = 5120;
  localparam int LARGE_RATE_HALF  = 29335;
  localparam int LARGE_WHEEL_HALF = 7333860;
  localparam int SMALL_PITCH_HALF = 1280;
  localparam int SMALL_RATE_HALF  = 14668;
  localparam int SMALL_WHEEL_HALF = 220016;

  // Duty limits and reset values of the configuration registers.
  localparam logic [11:0] DUTY_MAX         = 12'd2400;
  localparam logic [11:0] IDLE_DUTY_RST    = 12'd240;
  localparam logic [11:0] LARGE_DUTY_RST   = 12'd1984;
  localparam logic [11:0] SMALL_DUTY_RST   = 12'd738;
  localparam logic [15:0] THRESHOLD_RST    = 16'd1280;

  // APB address width: five 32-bit registers at byte addresses 0..16.
  localparam int PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_DRIVE_ENABLE     = 3'd0,
    REG_IDLE_DUTY        = 3'd1,
    REG_LARGE_RANGE_DUTY = 3'd2,
    REG_SMALL_RANGE_DUTY = 3'd3,
    REG_RANGE_THRESHOLD  = 3'd4
  } reg_idx_t;

  // Action codes as stored in the tables.
  localparam logic [1:0] ACT_IDLE     = 2'b00;
  localparam logic [1:0] ACT_FORWARD  = 2'b01;
  localparam logic [1:0] CODE_INVALID = 2'b10;

  // Range codes reported with each result.
  localparam logic [1:0] RANGE_LARGE = 2'd0;
  localparam logic [1:0] RANGE_SMALL = 2'd1;
  localparam logic [1:0] RANGE_NONE  = 2'd2;

  // Control of the table store for one cycle.
  typedef struct packed {
    logic en;
    logic large_we;
    logic small_we;
  } tbl_ctrl_t;

  // Number of divider stages in the quantizer for a given index width.
  function automatic int quant_div_stages(input int qw);
    return (qw + 1) >> 1;
  endfunction

endpackage
`default_nettype wire

// File: src/tpmd_quant.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid quantizer
// Pipelined nearest-grid-point index of a signed value on a uniform grid,
// ties to the lower index, clamped; two quotient bits resolved per stage.
// ----------------------------------------------------------------------------
module tpmd_quant import tpmd_pkg::*; #(
  parameter int N_LARGE = 40,
  parameter int N_SMALL = 40,
  parameter int H_LARGE = 5120,
  parameter int H_SMALL = 1280,
  parameter int QW      = 9
) (
  input  logic                clk,
  input  logic                adv,
  input  logic signed [23:0]  x,
  input  logic                sel_large,
  output logic [QW-1:0]       idx
);

  localparam int UW = 24 + QW;
  localparam int NS = quant_div_stages(QW);
  localparam logic [23:0] SPAN_L  = 24'(2 * H_LARGE);
  localparam logic [23:0] SPAN_S  = 24'(2 * H_SMALL);
  localparam logic [QW-1:0] NM1_L = QW'(N_LARGE - 1);
  localparam logic [QW-1:0] NM1_S = QW'(N_SMALL - 1);

  logic signed [24:0] t_s;
  logic               lo_c;
  logic               hi_c;
  logic [23:0]        t1;
  logic               lo1, hi1, lg1;
  logic [QW-1:0]      nm1;

  logic [UW-1:0]      rem [NS+1];
  logic [QW-1:0]      quo [NS+1];
  logic               lo_q [NS+1];
  logic               hi_q [NS+1];
  logic               lg_q [NS+1];

  // Offset onto the grid and find the clamped ends.
  always_comb begin
    t_s  = 25'(x) + (sel_large ? 25'(H_LARGE) : 25'(H_SMALL));
    lo_c = t_s[24] || (t_s == 25'sd0);
    hi_c = !lo_c && (t_s[23:0] >= (sel_large ? SPAN_L : SPAN_S));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1  <= t_s[23:0];
      lo1 <= lo_c;
      hi1 <= hi_c;
      lg1 <= sel_large;
    end
  end

  // Scale by the point count; adding H-1 makes the floor division round to the nearest point, ties down.
  assign nm1 = lg1 ? NM1_L : NM1_S;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= UW'(t1) * UW'(nm1)
               + (lg1 ? UW'(H_LARGE - 1) : UW'(H_SMALL - 1));
      quo[0]  <= '0;
      lo_q[0] <= lo1;
      hi_q[0] <= hi1;
      lg_q[0] <= lg1;
    end
  end

  // Restoring division by the grid span, two quotient bits per stage.
  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int B0 = QW - 1 - 2 * s;
    localparam int B1 = B0 - 1;
    logic [UW-1:0] span;
    logic [UW-1:0] r0, r1;
    logic [QW-1:0] q0, q1;

    assign span = UW'(lg_q[s] ? SPAN_L : SPAN_S);

    always_comb begin
      r0 = rem[s];
      q0 = quo[s];
      if (rem[s] >= (span << B0)) begin
        r0     = rem[s] - (span << B0);
        q0[B0] = 1'b1;
      end
    end

    if (B1 >= 0) begin : g_second
      always_comb begin
        r1 = r0;
        q1 = q0;
        if (r0 >= (span << B1)) begin
          r1     = r0 - (span << B1);
          q1[B1] = 1'b1;
        end
      end
    end else begin : g_last
      assign r1 = r0;
      assign q1 = q0;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s+1]  <= r1;
        quo[s+1]  <= q1;
        lo_q[s+1] <= lo_q[s];
        hi_q[s+1] <= hi_q[s];
        lg_q[s+1] <= lg_q[s];
      end
    end
  end

  // Apply the clamps at the grid ends.
  always_comb begin
    if (lo_q[NS]) begin
      idx = '0;
    end else if (hi_q[NS]) begin
      idx = lg_q[NS] ? NM1_L : NM1_S;
    end else begin
      idx = quo[NS];
    end
  end

endmodule
`default_nettype wire

// File: src/tpmd_tables.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Policy table store
// The large-range and small-range action tables, each a single-port
// synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module tpmd_tables import tpmd_pkg::*; #(
  parameter int LARGE_DEPTH = 1000000,
  parameter int SMALL_DEPTH = 400000,
  parameter int LARGE_AW    = 20,
  parameter int SMALL_AW    = 19
) (
  input  logic                clk,
  input  tbl_ctrl_t           ctrl,
  input  logic [LARGE_AW-1:0] large_addr,
  input  logic [SMALL_AW-1:0] small_addr,
  input  logic [1:0]          wdata,
  output logic [1:0]          large_rdata,
  output logic [1:0]          small_rdata
);

  logic [1:0] large_mem [LARGE_DEPTH];
  logic [1:0] small_mem [SMALL_DEPTH];

  // Large-range table: one access per cycle, read data held while stalled.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      if (ctrl.large_we) begin
        large_mem[large_addr] <= wdata;
      end
      large_rdata <= large_mem[large_addr];
    end
  end

  // Small-range table.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      if (ctrl.small_we) begin
        small_mem[small_addr] <= wdata;
      end
      small_rdata <= small_mem[small_addr];
    end
  end

endmodule
`default_nettype wire

// File: src/tabulated_policy_motor_drive_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tabulated policy motor drive unit
// Loads two action tables entry by entry and turns pitch, pitch rate and wheel
// rate samples into a motor action, direction and PWM duty.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | op, table_select, table_address,
//           |                      | table_code, pitch_angle, pitch_rate,
//           |                      | wheel_rate
//  out      | out_valid / out_ready| action, pwm_duty, direction,
//           |                      | drive_changed, range_used
//  config   | APB psel / penable   | paddr, pwdata, prdata (pready tied high)
//
// One transaction enters per cycle unless the pipe is stalled. QW, the index width
// of the largest grid (9 at the defaults), sizes the quantizer divider. Each result
// passes the quantizer divider, the two address multiplies and the table read.
// Reset is synchronous and clears control state and registers; table contents
// are undefined until loaded. A stalled output holds the whole pipe only when a
// result is waiting to leave its last stage.
// ----------------------------------------------------------------------------
module tabulated_policy_motor_drive_unit import tpmd_pkg::*; #(
  parameter int PITCH_POINTS       = 40,
  parameter int PITCH_RATE_POINTS  = 50,
  parameter int WHEEL_POINTS_LARGE = 500,
  parameter int WHEEL_POINTS_SMALL = 200
) (
  input  logic                clk,
  input  logic                rst,
  // Input transactions
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic                table_select,
  input  logic [19:0]         table_address,
  input  logic signed [1:0]   table_code,
  input  logic signed [23:0]  pitch_angle,
  input  logic signed [23:0]  pitch_rate,
  input  logic signed [23:0]  wheel_rate,
  // Result transactions
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [1:0]   action,
  output logic [11:0]         pwm_duty,
  output logic                direction,
  output logic                drive_changed,
  output logic [1:0]          range_used,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int LARGE_SIZE = PITCH_POINTS * PITCH_RATE_POINTS * WHEEL_POINTS_LARGE;
  localparam int SMALL_SIZE = PITCH_POINTS * PITCH_RATE_POINTS * WHEEL_POINTS_SMALL;
  localparam int LAW  = $clog2(LARGE_SIZE);
  localparam int SAW  = $clog2(SMALL_SIZE);
  localparam int AMAX = (LAW > SAW) ? LAW : SAW;
  localparam int PIW  = $clog2(PITCH_POINTS);
  localparam int RW   = $clog2(PITCH_RATE_POINTS);
  localparam int WMAX = (WHEEL_POINTS_LARGE > WHEEL_POINTS_SMALL) ?
                        WHEEL_POINTS_LARGE : WHEEL_POINTS_SMALL;
  localparam int KW   = $clog2(WMAX);
  localparam int JRW  = $clog2(PITCH_POINTS * PITCH_RATE_POINTS);
  localparam int NM_A = (PITCH_POINTS > PITCH_RATE_POINTS) ?
                        PITCH_POINTS : PITCH_RATE_POINTS;
  localparam int NMAX = (NM_A > WMAX) ? NM_A : WMAX;
  localparam int QW   = $clog2(NMAX);
  localparam int LAT  = 2 + quant_div_stages(QW);

  typedef struct packed {
    logic        valid;
    logic        op;
    logic        sel;
    logic [19:0] addr;
    logic [1:0]  code;
    logic        is_large;
    logic        on_thr;
  } side_t;

  // Configuration registers.
  logic        drive_enable;
  logic [11:0] idle_duty;
  logic [11:0] large_range_duty;
  logic [11:0] small_range_duty;
  logic [15:0] range_threshold;

  // Pipeline state.
  logic               adv;
  side_t              sb [LAT+1];
  side_t              in_side;
  logic [23:0]        mag;
  logic signed [23:0] p0_pitch, p0_rate, p0_wheel;
  logic [QW-1:0]      qi, qj, qk;
  logic [PIW-1:0]     ci;
  logic [RW-1:0]      cj;
  logic [KW-1:0]      ck;
  logic               c_hit;
  logic [PIW-1:0]     large_last_i, small_last_i;
  logic [RW-1:0]      large_last_j, small_last_j;

  side_t              a1_s, a2_s, m_s;
  logic               a1_hit, a2_hit, m_hit;
  logic [JRW-1:0]     a1_jr;
  logic [KW-1:0]      a1_k;
  logic [AMAX-1:0]    a2_addr;
  logic [AMAX-1:0]    wpts;

  tbl_ctrl_t          tctrl;
  logic [LAW-1:0]     tl_addr;
  logic [SAW-1:0]     ts_addr;
  logic [1:0]         tl_rd, ts_rd;

  // Drive state.
  logic [1:0]         applied_action;
  logic [11:0]        held_duty;
  logic               held_direction;
  logic [1:0]         rd_code;
  logic [1:0]         act;
  logic               take;
  logic [11:0]        duty_next;

  function automatic logic [11:0] sat_duty(input logic [31:0] v);
    return (v[11:0] > DUTY_MAX) ? DUTY_MAX : v[11:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration port: writes complete in the access phase.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_enable     <= 1'b0;
      idle_duty        <= IDLE_DUTY_RST;
      large_range_duty <= LARGE_DUTY_RST;
      small_range_duty <= SMALL_DUTY_RST;
      range_threshold  <= THRESHOLD_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_DRIVE_ENABLE:     drive_enable     <= pwdata[0];
        REG_IDLE_DUTY:        idle_duty        <= sat_duty(pwdata);
        REG_LARGE_RANGE_DUTY: large_range_duty <= sat_duty(pwdata);
        REG_SMALL_RANGE_DUTY: small_range_duty <= sat_duty(pwdata);
        REG_RANGE_THRESHOLD:  range_threshold  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_DRIVE_ENABLE:     prdata = 32'(drive_enable);
      REG_IDLE_DUTY:        prdata = 32'(idle_duty);
      REG_LARGE_RANGE_DUTY: prdata = 32'(large_range_duty);
      REG_SMALL_RANGE_DUTY: prdata = 32'(small_range_duty);
      REG_RANGE_THRESHOLD:  prdata = 32'(range_threshold);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Flow control: the pipe moves unless a finished result is blocked.
  // ---------------------------------------------------------------------
  assign adv      = !(out_valid && !out_ready && m_s.valid);
  assign in_ready = adv;

  // Range selection from the absolute pitch.
  always_comb begin
    mag                  = pitch_angle[23] ? (~pitch_angle + 24'd1) : pitch_angle;
    in_side.valid        = in_valid;
    in_side.op           = op;
    in_side.sel          = table_select;
    in_side.addr         = table_address;
    in_side.code         = table_code;
    in_side.is_large     = mag > 24'(range_threshold);
    in_side.on_thr       = mag == 24'(range_threshold);
  end

  // Input register and the sideband line that runs beside the quantizers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n <= LAT; n++) begin
        sb[n].valid <= 1'b0;
      end
    end else if (adv) begin
      sb[0] <= in_side;
      for (int n = 1; n <= LAT; n++) begin
        sb[n] <= sb[n-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_pitch <= pitch_angle;
      p0_rate  <= pitch_rate;
      p0_wheel <= wheel_rate;
    end
  end

  // ---------------------------------------------------------------------
  // Quantizers for the three axes.
  // ---------------------------------------------------------------------
  tpmd_quant #(
    .N_LARGE (PITCH_POINTS),
    .N_SMALL (PITCH_POINTS),
    .H_LARGE (LARGE_PITCH_HALF),
    .H_SMALL (SMALL_PITCH_HALF),
    .QW      (QW)
  ) u_quant_pitch (
    .clk       (clk),
    .adv       (adv),
    .x         (p0_pitch),
    .sel_large (sb[0].is_large),
    .idx       (qi)
  );

  tpmd_quant #(
    .N_LARGE (PITCH_RATE_POINTS),
    .N_SMALL (PITCH_RATE_POINTS),
    .H_LARGE (LARGE_RATE_HALF),
    .H_SMALL (SMALL_RATE_HALF),
    .QW      (QW)
  ) u_quant_rate (
    .clk       (clk),
    .adv       (adv),
    .x         (p0_rate),
    .sel_large (sb[0].is_large),
    .idx       (qj)
  );

  tpmd_quant #(
    .N_LARGE (WHEEL_POINTS_LARGE),
    .N_SMALL (WHEEL_POINTS_SMALL),
    .H_LARGE (LARGE_WHEEL_HALF),
    .H_SMALL (SMALL_WHEEL_HALF),
    .QW      (QW)
  ) u_quant_wheel (
    .clk       (clk),
    .adv       (adv),
    .x         (p0_wheel),
    .sel_large (sb[0].is_large),
    .idx       (qk)
  );

  // ---------------------------------------------------------------------
  // Compare with the remembered indices of the selected range.
  // ---------------------------------------------------------------------
  always_comb begin
    ci = qi[PIW-1:0];
    cj = qj[RW-1:0];
    ck = qk[KW-1:0];
    if (sb[LAT].is_large) begin
      c_hit = (ci != large_last_i) && (cj != large_last_j);
    end else begin
      c_hit = (ci != small_last_i) && (cj != small_last_j);
    end
    c_hit = c_hit && sb[LAT].valid && sb[LAT].op && !sb[LAT].on_thr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      large_last_i <= '0;
      large_last_j <= '0;
      small_last_i <= '0;
      small_last_j <= '0;
    end else if (adv && c_hit) begin
      if (sb[LAT].is_large) begin
        large_last_i <= ci;
        large_last_j <= cj;
      end else begin
        small_last_i <= ci;
        small_last_j <= cj;
      end
    end
  end

  // Address stage one: row of the pitch and rate indices.
  always_ff @(posedge clk) begin
    if (rst) begin
      a1_s.valid <= 1'b0;
    end else if (adv) begin
      a1_s <= sb[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_hit <= c_hit;
      a1_jr  <= JRW'(cj) + JRW'(JRW'(PITCH_RATE_POINTS) * JRW'(ci));
      a1_k   <= ck;
    end
  end

  // Address stage two: full flat table address.
  assign wpts = a1_s.is_large ? AMAX'(WHEEL_POINTS_LARGE) : AMAX'(WHEEL_POINTS_SMALL);

  always_ff @(posedge clk) begin
    if (rst) begin
      a2_s.valid <= 1'b0;
    end else if (adv) begin
      a2_s <= a1_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_hit  <= a1_hit;
      a2_addr <= AMAX'(a1_k) + AMAX'(wpts * AMAX'(a1_jr));
    end
  end

  // ---------------------------------------------------------------------
  // Table access: loads write, samples read, in transaction order.
  // ---------------------------------------------------------------------
  always_comb begin
    tctrl.en       = adv;
    tctrl.large_we = a2_s.valid && !a2_s.op && !a2_s.sel
                     && (32'(a2_s.addr) < 32'(LARGE_SIZE));
    tctrl.small_we = a2_s.valid && !a2_s.op && a2_s.sel
                     && (32'(a2_s.addr) < 32'(SMALL_SIZE));
    tl_addr        = a2_s.op ? LAW'(a2_addr) : LAW'(a2_s.addr);
    ts_addr        = a2_s.op ? SAW'(a2_addr) : SAW'(a2_s.addr);
  end

  tpmd_tables #(
    .LARGE_DEPTH (LARGE_SIZE),
    .SMALL_DEPTH (SMALL_SIZE),
    .LARGE_AW    (LAW),
    .SMALL_AW    (SAW)
  ) u_tables (
    .clk         (clk),
    .ctrl        (tctrl),
    .large_addr  (tl_addr),
    .small_addr  (ts_addr),
    .wdata       (a2_s.code),
    .large_rdata (tl_rd),
    .small_rdata (ts_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_s.valid <= 1'b0;
    end else if (adv) begin
      m_s <= a2_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_hit <= a2_hit;
    end
  end

  // ---------------------------------------------------------------------
  // Apply the looked-up action and register the result.
  // ---------------------------------------------------------------------
  always_comb begin
    rd_code   = m_s.is_large ? tl_rd : ts_rd;
    act       = (rd_code == CODE_INVALID) ? ACT_IDLE : rd_code;
    take      = m_s.valid && m_hit && drive_enable && (act != applied_action);
    if (act == ACT_IDLE) begin
      duty_next = idle_duty;
    end else begin
      duty_next = m_s.is_large ? large_range_duty : small_range_duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      applied_action <= ACT_IDLE;
      held_duty      <= IDLE_DUTY_RST;
      held_direction <= 1'b0;
    end else if (adv && take) begin
      applied_action <= act;
      held_duty      <= duty_next;
      if (act != ACT_IDLE) begin
        held_direction <= (act == ACT_FORWARD);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && m_s.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && m_s.valid) begin
      action        <= take ? act : applied_action;
      pwm_duty      <= take ? duty_next : held_duty;
      direction     <= (take && (act != ACT_IDLE)) ? (act == ACT_FORWARD) : held_direction;
      drive_changed <= take;
      if (m_s.op && !m_s.on_thr) begin
        range_used <= m_s.is_large ? RANGE_LARGE : RANGE_SMALL;
      end else begin
        range_used <= RANGE_NONE;
      end
    end
  end

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tabulated policy motor drive unit testbench
// Loads entries into both policy tables and sends pitch samples. A predictor
// in this file computes the motor drive that each transaction should produce.
// Results are checked field by field, in order, under random stalls on both
// channels. The register settings change between phases.
// ----------------------------------------------------------------------------
module tb;
  import tpmd_pkg::*;

  localparam int PITCH_POINTS       = 40;
  localparam int RATE_POINTS        = 50;
  localparam int WHEEL_POINTS_LARGE = 500;
  localparam int WHEEL_POINTS_SMALL = 200;
  localparam int LARGE_ENTRIES = PITCH_POINTS * RATE_POINTS * WHEEL_POINTS_LARGE;
  localparam int SMALL_ENTRIES = PITCH_POINTS * RATE_POINTS * WHEEL_POINTS_SMALL;

  localparam logic       OP_LOAD     = 1'b0;
  localparam logic       OP_SAMPLE   = 1'b1;
  localparam logic       TABLE_LARGE = 1'b0;
  localparam logic       TABLE_SMALL = 1'b1;
  localparam logic [1:0] ACT_REVERSE = 2'b11;

  localparam int PIPE_LATENCY = 12;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic               op;
    logic               tsel;
    logic [19:0]        taddr;
    logic signed [1:0]  tcode;
    logic signed [23:0] pitch;
    logic signed [23:0] prate;
    logic signed [23:0] wrate;
  } drive_cmd_t;

  typedef struct {
    logic signed [1:0] action;
    logic [11:0]       duty;
    logic              dir;
    logic              changed;
    logic [1:0]        rng;
  } drive_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               op = OP_LOAD;
  logic               table_select = TABLE_LARGE;
  logic [19:0]        table_address = '0;
  logic signed [1:0]  table_code = '0;
  logic signed [23:0] pitch_angle = '0;
  logic signed [23:0] pitch_rate = '0;
  logic signed [23:0] wheel_rate = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [1:0]  action;
  logic [11:0]        pwm_duty;
  logic               direction;
  logic               drive_changed;
  logic [1:0]         range_used;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Transactions waiting to be driven and drive outputs waiting to be seen.
  drive_cmd_t pending_cmds[$];
  drive_out_t expected_drive[$];
  drive_cmd_t cur_cmd;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Predictor state: register copies, table contents and motor state.
  logic        cfg_enable = 1'b0;
  logic [11:0] cfg_idle_duty = IDLE_DUTY_RST;
  logic [11:0] cfg_large_duty = LARGE_DUTY_RST;
  logic [11:0] cfg_small_duty = SMALL_DUTY_RST;
  int          cfg_thr = int'(THRESHOLD_RST);

  logic [1:0]        large_codes[int];
  logic [1:0]        small_codes[int];
  int                last_pitch_idx[2] = '{0, 0};
  int                last_rate_idx[2] = '{0, 0};
  logic signed [1:0] applied_act = ACT_IDLE;
  logic [11:0]       held_duty = IDLE_DUTY_RST;
  logic              held_dir = 1'b0;

  // Entries already loaded, as seen by the stimulus side.
  bit large_loaded[int];
  bit small_loaded[int];

  tabulated_policy_motor_drive_unit #(
    .PITCH_POINTS       (PITCH_POINTS),
    .PITCH_RATE_POINTS  (RATE_POINTS),
    .WHEEL_POINTS_LARGE (WHEEL_POINTS_LARGE),
    .WHEEL_POINTS_SMALL (WHEEL_POINTS_SMALL)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .table_select  (table_select),
    .table_address (table_address),
    .table_code    (table_code),
    .pitch_angle   (pitch_angle),
    .pitch_rate    (pitch_rate),
    .wheel_rate    (wheel_rate),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .pwm_duty      (pwm_duty),
    .direction     (direction),
    .drive_changed (drive_changed),
    .range_used    (range_used),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Nearest grid point of a symmetric uniform grid, ties to the lower index.
  function automatic int grid_index(longint x, longint half, int pts);
    longint t, num2, q;
    t = x + half;
    if (t <= 0) return 0;
    num2 = 2 * t * (pts - 1) - 2 * half;
    if (num2 <= 0) return 0;
    q = (num2 + 4 * half - 1) / (4 * half);
    if (q > pts - 1) q = pts - 1;
    return int'(q);
  endfunction

  // Grid indices of a sample and the flat table address they select.
  function automatic int locate(input bit big, input longint p, r, w, output int pi, ri);
    int wi, wpts;
    wpts = big ? WHEEL_POINTS_LARGE : WHEEL_POINTS_SMALL;
    pi = grid_index(p, big ? LARGE_PITCH_HALF : SMALL_PITCH_HALF, PITCH_POINTS);
    ri = grid_index(r, big ? LARGE_RATE_HALF : SMALL_RATE_HALF, RATE_POINTS);
    wi = grid_index(w, big ? LARGE_WHEEL_HALF : SMALL_WHEEL_HALF, wpts);
    return wi + wpts * (ri + RATE_POINTS * pi);
  endfunction

  function automatic logic [11:0] clip_duty(logic [11:0] v);
    return (v > DUTY_MAX) ? DUTY_MAX : v;
  endfunction

  // Drive outputs after one accepted transaction; updates the predictor state.
  function automatic drive_out_t predict_drive(drive_cmd_t c);
    drive_out_t res;
    longint mag;
    bit big;
    int pi, ri, addr;
    logic [1:0] code;
    logic signed [1:0] act;
    res.changed = 1'b0;
    res.rng = RANGE_NONE;
    if (c.op == OP_LOAD) begin
      if (c.tsel == TABLE_LARGE && c.taddr < LARGE_ENTRIES) begin
        large_codes[int'(c.taddr)] = c.tcode;
      end else if (c.tsel == TABLE_SMALL && c.taddr < SMALL_ENTRIES) begin
        small_codes[int'(c.taddr)] = c.tcode;
      end
    end else begin
      mag = (c.pitch < 0) ? -longint'(c.pitch) : longint'(c.pitch);
      if (mag != cfg_thr) begin
        big = mag > cfg_thr;
        res.rng = big ? RANGE_LARGE : RANGE_SMALL;
        addr = locate(big, c.pitch, c.prate, c.wrate, pi, ri);
        // The table is read only when both the pitch and rate index move.
        if (pi != last_pitch_idx[res.rng] && ri != last_rate_idx[res.rng]) begin
          if (big) code = large_codes.exists(addr) ? large_codes[addr] : ACT_IDLE;
          else code = small_codes.exists(addr) ? small_codes[addr] : ACT_IDLE;
          last_pitch_idx[res.rng] = pi;
          last_rate_idx[res.rng] = ri;
          act = (code == CODE_INVALID) ? ACT_IDLE : code;
          if (act != applied_act && cfg_enable) begin
            if (act == ACT_IDLE) begin
              held_duty = cfg_idle_duty;
            end else begin
              held_dir = (act == ACT_FORWARD);
              held_duty = big ? cfg_large_duty : cfg_small_duty;
            end
            applied_act = act;
            res.changed = 1'b1;
          end
        end
      end
    end
    res.action = applied_act;
    res.duty = held_duty;
    res.dir = held_dir;
    return res;
  endfunction

  task automatic check_field(string name, logic signed [12:0] want, logic signed [12:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: presents the next pending transaction, with random gaps.
  always @(posedge clk) begin : driver_b
    bit take_next;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_drive.push_back(predict_drive(cur_cmd));
      if (!in_valid || in_ready) begin
        take_next = pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (take_next) begin
          cur_cmd = pending_cmds.pop_front();
          op <= cur_cmd.op;
          table_select <= cur_cmd.tsel;
          table_address <= cur_cmd.taddr;
          table_code <= cur_cmd.tcode;
          pitch_angle <= cur_cmd.pitch;
          pitch_rate <= cur_cmd.prate;
          wheel_rate <= cur_cmd.wrate;
        end
        in_valid <= take_next;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expectation.
  always @(posedge clk) begin : monitor_b
    drive_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          $error("result transaction with no expectation pending");
          mismatch_count++;
        end else begin
          want = expected_drive.pop_front();
          check_field("action", want.action, action);
          check_field("pwm_duty", want.duty, pwm_duty);
          check_field("direction", want.dir, direction);
          check_field("drive_changed", want.changed, drive_changed);
          check_field("range_used", want.rng, range_used);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic drive_cmd_t random_cmd();
    drive_cmd_t c;
    c.op = 1'($urandom);
    c.tsel = 1'($urandom);
    c.taddr = 20'($urandom);
    c.tcode = 2'($urandom);
    c.pitch = 24'($urandom);
    c.prate = 24'($urandom);
    c.wrate = 24'($urandom);
    return c;
  endfunction

  task automatic queue_load(logic sel, int addr, logic [1:0] code);
    drive_cmd_t c;
    c = random_cmd();
    c.op = OP_LOAD;
    c.tsel = sel;
    c.taddr = 20'(addr);
    c.tcode = code;
    if (sel == TABLE_LARGE && addr < LARGE_ENTRIES) large_loaded[addr] = 1'b1;
    if (sel == TABLE_SMALL && addr < SMALL_ENTRIES) small_loaded[addr] = 1'b1;
    pending_cmds.push_back(c);
  endtask

  // A sample never reads an empty entry: the entry is loaded first if needed.
  task automatic queue_sample(int p, int r, int w);
    drive_cmd_t c;
    longint mag;
    bit big;
    int addr, pi, ri;
    mag = (p < 0) ? -longint'(p) : longint'(p);
    if (mag != cfg_thr) begin
      big = mag > cfg_thr;
      addr = locate(big, p, r, w, pi, ri);
      if (big && !large_loaded.exists(addr)) queue_load(TABLE_LARGE, addr, 2'($urandom));
      if (!big && !small_loaded.exists(addr)) queue_load(TABLE_SMALL, addr, 2'($urandom));
    end
    c = random_cmd();
    c.op = OP_SAMPLE;
    c.pitch = 24'(p);
    c.prate = 24'(r);
    c.wrate = 24'(w);
    pending_cmds.push_back(c);
  endtask

  // Mostly samples spread over the grids of either range, plus loads and noise.
  task automatic queue_random_items(int count);
    logic signed [23:0] np, nr, nw;
    int roll, mag, rh, wh, addr;
    bit big, sel;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        sel = 1'($urandom_range(1));
        if ($urandom_range(99) < 85) addr = $urandom_range(sel ? SMALL_ENTRIES - 1
                                                               : LARGE_ENTRIES - 1);
        else addr = $urandom_range(20'hFFFFF);
        queue_load(sel, addr, 2'($urandom));
      end else if (roll < 20) begin
        np = 24'($urandom);
        nr = 24'($urandom);
        nw = 24'($urandom);
        queue_sample(np, nr, nw);
      end else begin
        big = (cfg_thr == 0) || $urandom_range(1);
        if (roll < 26) mag = cfg_thr;
        else if (big) mag = cfg_thr + 1 + $urandom_range(6000);
        else mag = $urandom_range((cfg_thr - 1 < 1600) ? cfg_thr - 1 : 1600);
        rh = big ? LARGE_RATE_HALF : SMALL_RATE_HALF;
        wh = big ? LARGE_WHEEL_HALF : SMALL_WHEEL_HALF;
        queue_sample($urandom_range(1) ? -mag : mag,
                     int'($urandom_range(2 * rh + rh / 4)) - rh - rh / 8,
                     int'($urandom_range(2 * wh + wh / 4)) - wh - wh / 8);
      end
    end
  endtask

  // One APB write: setup cycle, then access cycle.
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DRIVE_ENABLE:     cfg_enable = val[0];
      REG_IDLE_DUTY:        cfg_idle_duty = clip_duty(val[11:0]);
      REG_LARGE_RANGE_DUTY: cfg_large_duty = clip_duty(val[11:0]);
      REG_SMALL_RANGE_DUTY: cfg_small_duty = clip_duty(val[11:0]);
      REG_RANGE_THRESHOLD:  cfg_thr = int'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] en_v, idle_v, large_v, small_v, thr_v);
    write_reg(REG_DRIVE_ENABLE, en_v);
    write_reg(REG_IDLE_DUTY, idle_v);
    write_reg(REG_LARGE_RANGE_DUTY, large_v);
    write_reg(REG_SMALL_RANGE_DUTY, small_v);
    write_reg(REG_RANGE_THRESHOLD, thr_v);
  endtask

  // Holds the sender until every expected result has left the block.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_drive.size() != 0);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  task automatic random_phase(int send_pct, int recv_pct,
                              logic [31:0] en_v, idle_v, large_v, small_v, thr_v);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    configure(en_v, idle_v, large_v, small_v, thr_v);
    queue_random_items(110);
    wait_drained();
    queue_random_items(110);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset register values, with drive enabled.
    send_idle_pct = 21;
    recv_stall_pct = 82;
    configure(32'd1, 32'(IDLE_DUTY_RST), 32'(LARGE_DUTY_RST), 32'(SMALL_DUTY_RST),
              32'(THRESHOLD_RST));
    queue_load(TABLE_LARGE, 0, ACT_FORWARD);
    queue_load(TABLE_LARGE, LARGE_ENTRIES - 1, ACT_REVERSE);
    queue_load(TABLE_LARGE, 20'hFFFFF, ACT_FORWARD);
    queue_load(TABLE_SMALL, SMALL_ENTRIES - 1, CODE_INVALID);
    queue_load(TABLE_SMALL, SMALL_ENTRIES, ACT_FORWARD);
    // Grid corners of both ranges; the small corner holds the invalid code.
    queue_sample(8388607, 8388607, 8388607);
    queue_sample(-8388608, -8388608, -8388608);
    queue_sample(1279, 8388607, 8388607);
    queue_sample(-1279, -8388608, -8388608);
    // Pitch right on the threshold, on either side of zero.
    queue_sample(1280, 0, 0);
    queue_sample(-1280, 5, 5);
    // Zero sits halfway between two grid points and rounds down.
    queue_sample(0, 0, 0);
    // Only the wheel index, then only one of pitch and rate, moves.
    queue_sample(0, 0, 8388607);
    queue_sample(900, 0, 0);
    queue_sample(0, 9000, 0);
    queue_load(TABLE_LARGE, 0, ACT_IDLE);
    queue_sample(-8388608, -8388608, -8388608);
    queue_sample(6000, 30000, 0);
    queue_sample(-5200, 30000, -7333860);
    queue_sample(-6000, -30000, 7333860);
    wait_drained();

    random_phase(21, 82, 32'd1, 32'd0, 32'(DUTY_MAX), 32'd0, 32'd0);
    random_phase(82, 21, 32'd0, $urandom_range(2400), $urandom_range(2400),
                 $urandom_range(2400), $urandom_range(3000));
    random_phase(82, 21, 32'd1, 32'hFFFF_FFFF, 32'h0000_0961, 32'hABCD_E123, 32'd46080);
    random_phase(0, 0, $urandom | 32'd1, $urandom, $urandom, $urandom,
                 $urandom_range(8000));
    random_phase(0, 0, 32'd1, $urandom_range(2400), $urandom_range(2400),
                 $urandom_range(2400), 32'hFFFF_FFFF);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
